// File: src/ptt_pkg.sv
// shared constants and types for the periodic timer table
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;
  localparam int unsigned SlotsDef = 16;

  localparam logic [1:0] CmdEnable  = 2'd0;
  localparam logic [1:0] CmdDisable = 2'd1;
  localparam logic [1:0] CmdTick    = 2'd2;
  localparam logic [1:0] CmdUnused  = 2'd3;

  localparam logic [1:0] KindAck  = 2'd0;
  localparam logic [1:0] KindFire = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatPresent = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic [1:0] StatMissing = 2'd3;

  typedef struct packed {
    logic [15:0]        owner;
    logic [15:0]        interval;
    logic signed [16:0] repeats;
    logic [15:0]        ticks;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic fin;
  } ptt_cmd_t;

  typedef struct packed {
    logic more;
    logic fire;
    logic out_free;
  } ptt_stat_t;
endpackage
`default_nettype wire

// File: src/ptt_ctrl.sv
// sequencer for the table walk
`timescale 1ns / 1ps
`default_nettype none
module ptt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [1:0]         in_cmd_i,
  output logic                    in_stall_o,
  input  wire ptt_pkg::ptt_stat_t stat_i,
  output ptt_pkg::ptt_cmd_t       cmd_o
);
  import ptt_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRd   = 2'd1;
  localparam logic [1:0] SProc = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_cmd_i != CmdUnused) state_d = SRd;
        end
      end
      SRd: begin
        if (stat_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = SProc;
        end else begin
          state_d = SFin;
        end
      end
      SProc: begin
        if (!stat_i.fire || stat_i.out_free) begin
          cmd_o.step = 1'b1;
          state_d    = SRd;
        end
      end
      SFin: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: src/ptt_datapath.sv
// timer table memory, walk pointers and result register
`timescale 1ns / 1ps
`default_nettype none
module ptt_datapath #(
  parameter int unsigned Slots = ptt_pkg::SlotsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_data_i,
  input  wire logic [1:0]         in_cmd_i,
  input  wire logic [15:0]        in_owner_id_i,
  input  wire logic [15:0]        in_interval_i,
  input  wire logic signed [16:0] in_repeat_count_i,
  input  wire ptt_pkg::ptt_cmd_t  cmd_i,
  output ptt_pkg::ptt_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              out_kind_o,
  output logic [15:0]             out_fired_owner_o,
  output logic [1:0]              out_status_o,
  output logic                    out_last_o
);
  import ptt_pkg::*;

  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [CW-1:0] SlotsC = CW'(Slots);

  entry_t             mem_q [Slots];
  entry_t             rdata_q;
  logic [CW-1:0]      count_q, r_q, w_q;
  logic               run_q, runs_q, found_q;
  logic [1:0]         cmd_q;
  logic [15:0]        own_q, ival_q;
  logic signed [16:0] reps_q;

  entry_t      ne;
  logic        keep, fire, match, hit, full, append;
  logic [15:0] t1;

  always_comb begin
    match = (rdata_q.owner == own_q);
    t1    = (rdata_q.ticks != 16'hFFFF) ? rdata_q.ticks + 16'd1 : rdata_q.ticks;
    hit   = (t1 >= rdata_q.interval);
    ne    = rdata_q;
    keep  = 1'b1;
    fire  = 1'b0;
    if (cmd_q == CmdTick && runs_q) begin
      ne.ticks = t1;
      if (hit) begin
        if (rdata_q.repeats[16]) begin
          ne.ticks = '0;
          fire     = 1'b1;
        end else if (rdata_q.repeats != '0) begin
          ne.repeats = rdata_q.repeats - 17'sd1;
          ne.ticks   = '0;
          fire       = 1'b1;
        end else begin
          keep = 1'b0;
        end
      end
    end
    if (cmd_q == CmdDisable && match) keep = 1'b0;
  end

  assign full   = (count_q == SlotsC);
  assign append = (cmd_q == CmdEnable) && !found_q && !full;

  assign stat_o.more     = (r_q < count_q);
  assign stat_o.fire     = fire;
  assign stat_o.out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rdata_q <= mem_q[r_q[IW-1:0]];
    if (cmd_i.step && keep) begin
      mem_q[w_q[IW-1:0]] <= ne;
    end else if (cmd_i.fin && append) begin
      mem_q[count_q[IW-1:0]] <= '{owner: own_q, interval: ival_q, repeats: reps_q,
                                  ticks: 16'd0};
    end
    if (cmd_i.load) begin
      cmd_q  <= in_cmd_i;
      own_q  <= in_owner_id_i;
      ival_q <= in_interval_i;
      reps_q <= in_repeat_count_i;
    end
    if (cmd_i.fin) begin
      out_last_o <= 1'b1;
      if (cmd_q == CmdTick) begin
        out_kind_o        <= KindDone;
        out_fired_owner_o <= '0;
        out_status_o      <= StatOk;
      end else begin
        out_kind_o        <= KindAck;
        out_fired_owner_o <= own_q;
        if (cmd_q == CmdEnable) begin
          out_status_o <= found_q ? StatPresent : (full ? StatFull : StatOk);
        end else begin
          out_status_o <= found_q ? StatOk : StatMissing;
        end
      end
    end else if (cmd_i.step && fire) begin
      out_last_o        <= 1'b0;
      out_kind_o        <= KindFire;
      out_fired_owner_o <= rdata_q.owner;
      out_status_o      <= StatOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      runs_q      <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      r_q         <= '0;
      w_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) run_q <= cfg_data_i;
      if (cmd_i.load) begin
        runs_q  <= run_q;
        found_q <= 1'b0;
        r_q     <= '0;
        w_q     <= '0;
      end
      if (cmd_i.step) begin
        r_q <= r_q + 1'b1;
        if (keep) w_q <= w_q + 1'b1;
        if (match && cmd_q != CmdTick) found_q <= 1'b1;
      end
      if (cmd_i.fin) count_q <= w_q + CW'(append);
      if (cmd_i.fin || (cmd_i.step && fire)) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/periodic_timer_table_unit.sv
// top level of the periodic timer table
// Ordered table of up to Slots periodic timers kept in a single-port memory. Every command
// (enable, disable, tick) walks the valid entries in table order, reading each entry and
// writing back the entries it keeps, so it compacts the table as it goes; the walk waits for
// a stalled output before it emits a word. Fires are emitted in table order during a tick
// walk; the final word of each item has last set. Command code three is consumed with no
// result. The user must write the running register through the cfg port only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_table_unit #(
  parameter int unsigned Slots = ptt_pkg::SlotsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [15:0]        owner_id_i,
  input  wire logic [15:0]        interval_i,
  input  wire logic signed [16:0] repeat_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              kind_o,
  output logic [15:0]             fired_owner_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);
  import ptt_pkg::*;

  ptt_cmd_t  cmd;
  ptt_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptt_datapath #(.Slots(Slots)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .in_cmd_i          (cmd_i),
    .in_owner_id_i     (owner_id_i),
    .in_interval_i     (interval_i),
    .in_repeat_count_i (repeat_count_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (kind_o),
    .out_fired_owner_o (fired_owner_o),
    .out_status_o      (status_o),
    .out_last_o        (last_o)
  );
endmodule
`default_nettype wire

// File: src/ptt_checker.sv
// port-level checks for the periodic timer table
`timescale 1ns / 1ps
`default_nettype none
module ptt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  cmd_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [15:0] fired_owner_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_o
);
  import ptt_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i != CmdUnused |=> in_stall_o)
    else $error("accepted command not held busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(fired_owner_o)
      && $stable(status_o) && $stable(last_o))
    else $error("stalled word changed");

  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindFire |-> !last_o && status_o == StatOk)
    else $error("fire word marked last");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindDone |-> last_o && fired_owner_o == 16'd0
      && status_o == StatOk)
    else $error("bad tick done word");
endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cmd_i         (cmd_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .fired_owner_o (fired_owner_o),
  .status_o      (status_o),
  .last_o        (last_o)
);
`default_nettype wire

// File: dv/periodic_timer_table_unit_tb.sv
// self-checking testbench for the periodic timer table with a built-in table predictor
`timescale 1ns / 1ps
module periodic_timer_table_unit_tb;
  import ptt_pkg::*;

  localparam int Slots = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] owner;
    logic [1:0]  status;
    logic        last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [15:0] owner_id = '0;
  logic [15:0] interval = '0;
  logic signed [16:0] repeat_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [15:0] fired_owner;
  logic [1:0] status;
  logic last;

  periodic_timer_table_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .owner_id_i(owner_id), .interval_i(interval),
    .repeat_count_i(repeat_count),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .fired_owner_o(fired_owner), .status_o(status), .last_o(last)
  );

  always #4 clk = ~clk;

  // predictor state
  logic               tbl_run;
  int                 tbl_count;
  logic [15:0]        tbl_owner[Slots];
  logic [15:0]        tbl_ival[Slots];
  logic signed [16:0] tbl_reps[Slots];
  logic [15:0]        tbl_ticks[Slots];

  word_t pending_words[$];
  int errors = 0;
  int mismatches = 0;
  int items_sent = 0;
  int words_seen = 0;
  int fires_seen = 0;
  int send_idle = 0;
  int recv_stall = 0;

  function automatic int find_owner(logic [15:0] o);
    for (int i = 0; i < tbl_count; i++) if (tbl_owner[i] == o) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int p);
    for (int i = p; i + 1 < tbl_count; i++) begin
      tbl_owner[i] = tbl_owner[i+1];
      tbl_ival[i] = tbl_ival[i+1];
      tbl_reps[i] = tbl_reps[i+1];
      tbl_ticks[i] = tbl_ticks[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void push_word(logic [1:0] k, logic [15:0] o, logic [1:0] s, logic l);
    word_t w;
    w.kind = k;
    w.owner = o;
    w.status = s;
    w.last = l;
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void predict_table(logic [1:0] c, logic [15:0] o, logic [15:0] iv,
                                        logic signed [16:0] rp);
    int p;
    int i;
    case (c)
      CmdEnable: begin
        if (find_owner(o) >= 0) push_word(KindAck, o, StatPresent, 1'b1);
        else if (tbl_count >= Slots) push_word(KindAck, o, StatFull, 1'b1);
        else begin
          tbl_owner[tbl_count] = o;
          tbl_ival[tbl_count] = iv;
          tbl_reps[tbl_count] = rp;
          tbl_ticks[tbl_count] = '0;
          tbl_count++;
          push_word(KindAck, o, StatOk, 1'b1);
        end
      end
      CmdDisable: begin
        p = find_owner(o);
        if (p >= 0) begin
          drop_entry(p);
          push_word(KindAck, o, StatOk, 1'b1);
        end else begin
          push_word(KindAck, o, StatMissing, 1'b1);
        end
      end
      CmdTick: begin
        if (tbl_run) begin
          i = 0;
          while (i < tbl_count) begin
            if (tbl_ticks[i] != 16'hFFFF) tbl_ticks[i]++;
            if (tbl_ticks[i] >= tbl_ival[i]) begin
              if (tbl_reps[i] < 0) begin
                tbl_ticks[i] = '0;
                push_word(KindFire, tbl_owner[i], StatOk, 1'b0);
              end else if (tbl_reps[i] > 0) begin
                tbl_reps[i]--;
                tbl_ticks[i] = '0;
                push_word(KindFire, tbl_owner[i], StatOk, 1'b0);
              end else begin
                drop_entry(i);
                continue;
              end
            end
            i++;
          end
        end
        push_word(KindDone, 16'd0, StatOk, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] c, logic [15:0] o, logic [15:0] iv,
                           logic signed [16:0] rp);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= c;
    owner_id <= o;
    interval <= iv;
    repeat_count <= rp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table(c, o, iv, rp);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_words.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (2 * Slots + 10) @(negedge clk);
  endtask

  task automatic write_running(logic v);
    wait_drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tbl_run = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pressure(int s, int r);
    send_idle = s;
    recv_stall = r;
  endtask

  // result checker
  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (kind == KindFire) fires_seen++;
      if (pending_words.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected word kind=%0d owner=%0d status=%0d last=%0d",
                   kind, fired_owner, status, last);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        if (w.kind !== kind || w.owner !== fired_owner || w.status !== status ||
            w.last !== last) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch exp kind=%0d owner=%0d status=%0d last=%0d got %0d %0d %0d %0d",
                     w.kind, w.owner, w.status, w.last, kind, fired_owner, status, last);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  task automatic test_directed();
    set_pressure(0, 0);
    send_item(CmdTick, 16'd0, 16'd0, 17'sd0);
    write_running(1'b1);
    send_item(CmdEnable, 16'd0, 16'd0, -17'sd1);
    send_item(CmdEnable, 16'hFFFF, 16'hFFFF, 17'sd65535);
    send_item(CmdEnable, 16'hFFFF, 16'd3, 17'sd2);
    send_item(CmdEnable, 16'd5, 16'd1, 17'sd1);
    send_item(CmdEnable, 16'd6, 16'd2, 17'sd0);
    send_item(CmdEnable, 16'd7, 16'd1, 17'sh10000);
    send_item(CmdDisable, 16'd1234, 16'd0, 17'sd0);
    send_item(CmdUnused, 16'hAAAA, 16'h5555, -17'sd1);
    send_item(CmdTick, 16'd0, 16'd0, 17'sd0);
    send_item(CmdTick, 16'hFFFF, 16'hFFFF, -17'sd1);
    send_item(CmdTick, 16'd0, 16'd0, 17'sd0);
    send_item(CmdDisable, 16'hFFFF, 16'd0, 17'sd0);
    for (int i = 0; i < 17; i++)
      send_item(CmdEnable, 16'(100 + i), 16'd1 + 16'(i[3:0]), -17'sd1);
    send_item(CmdTick, 16'd0, 16'd0, 17'sd0);
    write_running(1'b0);
    send_item(CmdTick, 16'd0, 16'd0, 17'sd0);
    for (int i = 0; i < 17; i++) send_item(CmdDisable, 16'(100 + i), 16'd0, 17'sd0);
    send_item(CmdDisable, 16'd0, 16'd0, 17'sd0);
    send_item(CmdDisable, 16'd5, 16'd0, 17'sd0);
    send_item(CmdDisable, 16'd7, 16'd0, 17'sd0);
    wait_drain();
  endtask

  // random mix of enables, disables, ticks and unused codes, mostly with small intervals, so fires and expiries happen
  task automatic random_burst(int n);
    logic [1:0] c;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      c = (r < 40) ? CmdEnable : (r < 60) ? CmdDisable : (r < 95) ? CmdTick : CmdUnused;
      send_item(c, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)),
                ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
                ($urandom_range(5) == 0) ? 17'($urandom) :
                17'(int'($urandom_range(5)) - 1));
    end
  endtask

  task automatic test_random();
    write_running(1'b1);
    set_pressure(0, 0);
    random_burst(15);
    set_pressure(86, 0);
    random_burst(15);
    write_running(1'b0);
    set_pressure(0, 86);
    random_burst(15);
    write_running(1'b1);
    set_pressure(19, 19);
    random_burst(23);
    set_pressure(0, 0);
    wait_drain();
  endtask

  initial begin
    tbl_run = 1'b0;
    tbl_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    $display("sent %0d items, checked %0d words including %0d fires", items_sent,
             words_seen, fires_seen);
    $display("covered enable, disable, tick, unused code, full table and running on/off");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("periodic_timer_table_unit_tb OK");
    end else begin
      $display("periodic_timer_table_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("periodic_timer_table_unit_tb NOT OK");
    $finish;
  end
endmodule
